// ===== hdl/beat_grid_line_generator_macros.svh =====
// ---------------------------------------------------------------------------
// beat grid line generator assertion macros
// immediate-cycle and next-cycle implication checks on clk_i / rst_ni
// ---------------------------------------------------------------------------
`ifndef BEAT_GRID_LINE_GENERATOR_MACROS_SVH
`define BEAT_GRID_LINE_GENERATOR_MACROS_SVH

// antecedent and consequent in the same cycle
`define BGL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("beat grid line check failed");

// consequent in the cycle after the antecedent
`define BGL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("beat grid line check failed");

`endif

// ===== hdl/bgl_pkg.sv =====
// ---------------------------------------------------------------------------
// bgl_pkg
// shared constants, register indexes, micro-op codes and control structs
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bgl_pkg;

  localparam int unsigned MAX_LINES = 64;
  localparam int unsigned LIMIT_W   = 7;
  localparam int unsigned WIDE_W    = 64;
  localparam int unsigned STEP_CNT_W = 7;

  // 6e9 us per centi-bpm minute in q16
  localparam logic [WIDE_W-1:0] STEP_NUM = 64'd393216000000000;

  localparam logic [2:0] REG_TEMPO  = 3'd0;
  localparam logic [2:0] REG_SUBDIV = 3'd1;
  localparam logic [2:0] REG_BEATS  = 3'd2;
  localparam logic [2:0] REG_OFFSET = 3'd3;
  localparam logic [2:0] REG_LIMIT  = 3'd4;

  localparam logic [16:0] TEMPO_RST  = 17'd12000;
  localparam logic [4:0]  SUBDIV_RST = 5'd4;
  localparam logic [4:0]  BEATS_RST  = 5'd4;
  localparam logic [31:0] OFFSET_RST = 32'd0;
  localparam logic [6:0]  LIMIT_RST  = 7'd64;

  typedef enum logic [4:0] {
    OP_LOAD,
    OP_STEP,
    OP_BAR,
    OP_PHASE,
    OP_FIRST,
    OP_LAST,
    OP_COUNT,
    OP_BEATDIV,
    OP_BARDIV,
    OP_CEILDIV,
    OP_STRIDEMUL,
    OP_ALIGN,
    OP_INC,
    OP_ACC,
    OP_NORM,
    OP_BEAT,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    STRIDE_SUB,
    STRIDE_BEAT,
    STRIDE_BAR
  } stride_e;

  typedef struct packed {
    logic [16:0]        tempo;
    logic [4:0]         subdiv;
    logic [4:0]         beats;
    logic signed [31:0] offset;
    logic [6:0]         limit;
  } cfg_t;

  typedef struct packed {
    logic go;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic degenerate;
    logic empty;
    logic over;
    logic more;
    logic last_line;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/bgl_div.sv =====
// ---------------------------------------------------------------------------
// bgl_div
// unsigned 64 by 64 bit restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bgl_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [bgl_pkg::WIDE_W-1:0]    num_i,
  input  wire logic [bgl_pkg::WIDE_W-1:0]    den_i,
  output logic                               done_o,
  output logic [bgl_pkg::WIDE_W-1:0]         quo_o,
  output logic [bgl_pkg::WIDE_W-1:0]         rem_o
);

  logic [bgl_pkg::WIDE_W-1:0]     num_q, num_d;
  logic [bgl_pkg::WIDE_W-1:0]     den_q, den_d;
  logic [bgl_pkg::WIDE_W-1:0]     rem_q, rem_d;
  logic [bgl_pkg::STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [bgl_pkg::WIDE_W:0]       trial;

  assign trial = {rem_q, num_q[bgl_pkg::WIDE_W-1]} - {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[bgl_pkg::WIDE_W]) begin
        rem_d = {rem_q[bgl_pkg::WIDE_W-2:0], num_q[bgl_pkg::WIDE_W-1]};
      end else begin
        rem_d = trial[bgl_pkg::WIDE_W-1:0];
      end
      num_d = {num_q[bgl_pkg::WIDE_W-2:0], ~trial[bgl_pkg::WIDE_W]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == bgl_pkg::STEP_CNT_W'(bgl_pkg::WIDE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== hdl/bgl_mul.sv =====
// ---------------------------------------------------------------------------
// bgl_mul
// shift-add multiplier, low 64 bits of the product, stops when b runs out
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bgl_mul (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [bgl_pkg::WIDE_W-1:0] a_i,
  input  wire logic [bgl_pkg::WIDE_W-1:0] b_i,
  output logic                            done_o,
  output logic [bgl_pkg::WIDE_W-1:0]      prod_o
);

  logic [bgl_pkg::WIDE_W-1:0] a_q, a_d;
  logic [bgl_pkg::WIDE_W-1:0] b_q, b_d;
  logic [bgl_pkg::WIDE_W-1:0] p_q, p_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      p_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (b_q[0]) begin
          p_d = p_q + a_q;
        end
        a_d = {a_q[bgl_pkg::WIDE_W-2:0], 1'b0};
        b_d = {1'b0, b_q[bgl_pkg::WIDE_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

`default_nettype wire

// ===== hdl/bgl_dp.sv =====
// ---------------------------------------------------------------------------
// bgl_dp
// grid arithmetic: shared divider and multiplier, window state, line stepper
// and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bgl_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bgl_pkg::cfg_t       cfg_i,
  input  wire bgl_pkg::cmd_t       cmd_i,
  input  wire logic [31:0]         window_start_us_i,
  input  wire logic [31:0]         window_end_us_i,
  output bgl_pkg::status_t         status_o,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output logic signed [33:0]       line_time_us_o,
  output logic                     on_bar_o,
  output logic                     on_beat_o,
  output logic [4:0]               beat_number_o,
  output logic                     final_line_o
);

  localparam int unsigned W = bgl_pkg::WIDE_W;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    mag = v[W-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  // derived settings
  logic [21:0]                 den;
  logic [9:0]                  spbar;
  logic [bgl_pkg::LIMIT_W-1:0] limit;
  logic [W-1:0]                spbar_w, subdiv_w, limit_w;

  assign den   = cfg_i.tempo * cfg_i.subdiv;
  assign spbar = cfg_i.subdiv * cfg_i.beats;
  assign limit = (cfg_i.limit > bgl_pkg::LIMIT_W'(bgl_pkg::MAX_LINES)) ?
                 bgl_pkg::LIMIT_W'(bgl_pkg::MAX_LINES) : cfg_i.limit;
  assign spbar_w  = {{(W-10){1'b0}}, spbar};
  assign subdiv_w = {{(W-5){1'b0}}, cfg_i.subdiv};
  assign limit_w  = {{(W-bgl_pkg::LIMIT_W){1'b0}}, limit};

  // registers
  bgl_pkg::op_e               op_q, op_d;
  logic [31:0]                start_q, start_d, end_q, end_d;
  logic [W-1:0]               step_q, step_d, bar_q, bar_d;
  logic signed [W-1:0]        phase_q, phase_d, first_q, first_d, last_q, last_d;
  logic [W-1:0]               count_q, count_d, stride_q, stride_d;
  logic [W-1:0]               barcnt_q, barcnt_d, scratch_q, scratch_d, inc_q, inc_d;
  logic signed [W-1:0]        idx_q, idx_d, acc_q, acc_d;
  logic [9:0]                 norm_q, norm_d;
  logic [4:0]                 sub_q, sub_d, beat_q, beat_d;
  logic [bgl_pkg::LIMIT_W-1:0] n_q, n_d;
  bgl_pkg::stride_e           kind_q, kind_d;
  logic                       over_q, over_d, degen_q, degen_d;
  logic                       done_q, done_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [33:0]         time_q, time_d;
  logic                       bar_flag_q, bar_flag_d, beat_flag_q, beat_flag_d;
  logic [4:0]                 beat_num_q, beat_num_d;
  logic                       final_q, final_d;

  // units
  logic         div_start, div_done, mul_start, mul_done;
  logic [W-1:0] div_num, div_den, div_quo, div_rem;
  logic [W-1:0] mul_a, mul_b, mul_prod;

  logic signed [W-1:0] win_a, win_b, next_idx, rounded, cnt_new;
  logic                is_div, is_mul, emit, more, last_line, out_free;

  assign win_a    = $signed({16'd0, start_q, 16'd0}) - phase_q;
  assign win_b    = $signed({16'd0, end_q, 16'd0}) - phase_q;
  assign next_idx = idx_q + $signed(stride_q);
  assign rounded  = acc_q + 64'sd32768;
  assign cnt_new  = last_q - first_q + 64'sd1;

  assign more      = (idx_q <= last_q) && (n_q < limit);
  assign last_line = (next_idx > last_q) || ((n_q + 1'b1) == limit);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = cmd_i.go && (cmd_i.op == bgl_pkg::OP_EMIT);

  always_comb begin
    is_div  = 1'b0;
    is_mul  = 1'b0;
    div_num = '0;
    div_den = '0;
    mul_a   = '0;
    mul_b   = '0;
    case (cmd_i.op)
      bgl_pkg::OP_STEP: begin
        is_div  = 1'b1;
        div_num = bgl_pkg::STEP_NUM + {{(W-21){1'b0}}, den[21:1]};
        div_den = {{(W-22){1'b0}}, den};
      end
      bgl_pkg::OP_PHASE: begin
        is_div  = 1'b1;
        div_num = mag(W'(cfg_i.offset)) << 16;
        div_den = bar_q;
      end
      bgl_pkg::OP_FIRST: begin
        is_div  = 1'b1;
        div_num = mag(win_a);
        div_den = step_q;
      end
      bgl_pkg::OP_LAST: begin
        is_div  = 1'b1;
        div_num = mag(win_b);
        div_den = step_q;
      end
      bgl_pkg::OP_BEATDIV: begin
        is_div  = 1'b1;
        div_num = count_q;
        div_den = subdiv_w;
      end
      bgl_pkg::OP_BARDIV: begin
        is_div  = 1'b1;
        div_num = count_q;
        div_den = spbar_w;
      end
      bgl_pkg::OP_CEILDIV: begin
        is_div  = 1'b1;
        div_num = barcnt_q + limit_w - 64'd1;
        div_den = limit_w;
      end
      bgl_pkg::OP_ALIGN: begin
        is_div  = 1'b1;
        div_num = mag(first_q);
        div_den = stride_q;
      end
      bgl_pkg::OP_NORM: begin
        is_div  = 1'b1;
        div_num = mag(idx_q);
        div_den = spbar_w;
      end
      bgl_pkg::OP_BEAT: begin
        is_div  = 1'b1;
        div_num = {{(W-10){1'b0}}, norm_q};
        div_den = subdiv_w;
      end
      bgl_pkg::OP_BAR: begin
        is_mul = 1'b1;
        mul_a  = step_q;
        mul_b  = spbar_w;
      end
      bgl_pkg::OP_STRIDEMUL: begin
        is_mul = 1'b1;
        mul_a  = spbar_w;
        mul_b  = scratch_q;
      end
      bgl_pkg::OP_INC: begin
        is_mul = 1'b1;
        mul_a  = step_q;
        mul_b  = stride_q;
      end
      bgl_pkg::OP_ACC: begin
        is_mul = 1'b1;
        mul_a  = step_q;
        mul_b  = mag(idx_q);
      end
      default: begin
        is_div = 1'b0;
        is_mul = 1'b0;
      end
    endcase
  end

  assign div_start = cmd_i.go && is_div;
  assign mul_start = cmd_i.go && is_mul;

  bgl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  bgl_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_comb begin
    op_d        = op_q;
    start_d     = start_q;
    end_d       = end_q;
    step_d      = step_q;
    bar_d       = bar_q;
    phase_d     = phase_q;
    first_d     = first_q;
    last_d      = last_q;
    count_d     = count_q;
    stride_d    = stride_q;
    barcnt_d    = barcnt_q;
    scratch_d   = scratch_q;
    inc_d       = inc_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    norm_d      = norm_q;
    sub_d       = sub_q;
    beat_d      = beat_q;
    n_d         = n_q;
    kind_d      = kind_q;
    over_d      = over_q;
    degen_d     = degen_q;
    time_d      = time_q;
    bar_flag_d  = bar_flag_q;
    beat_flag_d = beat_flag_q;
    beat_num_d  = beat_num_q;
    final_d     = final_q;
    out_valid_d = out_valid_q && out_stall_i;
    done_d      = div_done || mul_done ||
                  (cmd_i.go && !is_div && !is_mul && !emit);

    if (cmd_i.go) begin
      op_d = cmd_i.op;
    end

    if (cmd_i.go && (cmd_i.op == bgl_pkg::OP_LOAD)) begin
      start_d = window_start_us_i;
      end_d   = window_end_us_i;
      n_d     = '0;
      degen_d = (window_end_us_i < window_start_us_i) || (cfg_i.tempo == '0) ||
                (cfg_i.subdiv == '0) || (cfg_i.beats == '0) || (limit == '0);
    end

    if (cmd_i.go && (cmd_i.op == bgl_pkg::OP_COUNT)) begin
      count_d  = $unsigned(cnt_new);
      stride_d = 64'd1;
      kind_d   = bgl_pkg::STRIDE_SUB;
      over_d   = $unsigned(cnt_new) > limit_w;
    end

    if (div_done) begin
      case (op_q)
        bgl_pkg::OP_STEP:  step_d = div_quo;
        bgl_pkg::OP_PHASE: phase_d = cfg_i.offset[31] ? -$signed(div_rem) : $signed(div_rem);
        bgl_pkg::OP_FIRST: begin
          if (win_a[W-1]) begin
            first_d = -$signed(div_quo);
          end else begin
            first_d = $signed(div_quo) + $signed({{(W-1){1'b0}}, (div_rem != '0)});
          end
        end
        bgl_pkg::OP_LAST: begin
          if (win_b[W-1]) begin
            last_d = -($signed(div_quo) + $signed({{(W-1){1'b0}}, (div_rem != '0)}));
          end else begin
            last_d = $signed(div_quo);
          end
        end
        bgl_pkg::OP_BEATDIV: begin
          stride_d = subdiv_w;
          kind_d   = bgl_pkg::STRIDE_BEAT;
          over_d   = (div_quo + 64'd2) > limit_w;
        end
        bgl_pkg::OP_BARDIV: begin
          stride_d = spbar_w;
          kind_d   = bgl_pkg::STRIDE_BAR;
          barcnt_d = div_quo + 64'd2;
          over_d   = (div_quo + 64'd2) > limit_w;
        end
        bgl_pkg::OP_CEILDIV: scratch_d = div_quo;
        bgl_pkg::OP_ALIGN: begin
          if (first_q[W-1]) begin
            idx_d = first_q + $signed(div_rem);
          end else if (div_rem == '0) begin
            idx_d = first_q;
          end else begin
            idx_d = first_q + $signed(stride_q - div_rem);
          end
        end
        bgl_pkg::OP_NORM: begin
          if (idx_q[W-1] && (div_rem != '0)) begin
            norm_d = spbar - div_rem[9:0];
          end else begin
            norm_d = div_rem[9:0];
          end
        end
        bgl_pkg::OP_BEAT: begin
          beat_d = div_quo[4:0];
          sub_d  = div_rem[4:0];
        end
        default: begin
          step_d = step_q;
        end
      endcase
    end

    if (mul_done) begin
      case (op_q)
        bgl_pkg::OP_BAR:       bar_d = mul_prod;
        bgl_pkg::OP_STRIDEMUL: stride_d = mul_prod;
        bgl_pkg::OP_INC:       inc_d = mul_prod;
        bgl_pkg::OP_ACC: begin
          acc_d = phase_q + (idx_q[W-1] ? -$signed(mul_prod) : $signed(mul_prod));
        end
        default: begin
          bar_d = bar_q;
        end
      endcase
    end

    if (emit) begin
      out_valid_d = 1'b1;
      time_d      = rounded[49:16];
      bar_flag_d  = (sub_q == '0) && (beat_q == '0);
      beat_flag_d = (sub_q == '0);
      beat_num_d  = (sub_q == '0) ? beat_q : cfg_i.beats;
      final_d     = last_line;
      idx_d       = next_idx;
      acc_d       = acc_q + $signed(inc_q);
      n_d         = n_q + 1'b1;
      case (kind_q)
        bgl_pkg::STRIDE_SUB: begin
          if ((sub_q + 5'd1) == cfg_i.subdiv) begin
            sub_d  = '0;
            beat_d = ((beat_q + 5'd1) == cfg_i.beats) ? 5'd0 : beat_q + 5'd1;
          end else begin
            sub_d = sub_q + 5'd1;
          end
        end
        bgl_pkg::STRIDE_BEAT: begin
          beat_d = ((beat_q + 5'd1) == cfg_i.beats) ? 5'd0 : beat_q + 5'd1;
        end
        default: begin
          beat_d = beat_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= bgl_pkg::OP_LOAD;
      over_q      <= 1'b0;
      degen_q     <= 1'b0;
      n_q         <= '0;
      kind_q      <= bgl_pkg::STRIDE_SUB;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
      over_q      <= over_d;
      degen_q     <= degen_d;
      n_q         <= n_d;
      kind_q      <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    end_q       <= end_d;
    step_q      <= step_d;
    bar_q       <= bar_d;
    phase_q     <= phase_d;
    first_q     <= first_d;
    last_q      <= last_d;
    count_q     <= count_d;
    stride_q    <= stride_d;
    barcnt_q    <= barcnt_d;
    scratch_q   <= scratch_d;
    inc_q       <= inc_d;
    idx_q       <= idx_d;
    acc_q       <= acc_d;
    norm_q      <= norm_d;
    sub_q       <= sub_d;
    beat_q      <= beat_d;
    time_q      <= time_d;
    bar_flag_q  <= bar_flag_d;
    beat_flag_q <= beat_flag_d;
    beat_num_q  <= beat_num_d;
    final_q     <= final_d;
  end

  assign status_o.done       = done_q;
  assign status_o.degenerate = degen_q;
  assign status_o.empty      = last_q < first_q;
  assign status_o.over       = over_q;
  assign status_o.more       = more;
  assign status_o.last_line  = last_line;
  assign status_o.out_free   = out_free;

  assign out_valid_o    = out_valid_q;
  assign line_time_us_o = time_q;
  assign on_bar_o       = bar_flag_q;
  assign on_beat_o      = beat_flag_q;
  assign beat_number_o  = beat_num_q;
  assign final_line_o   = final_q;

endmodule

`default_nettype wire

// ===== hdl/bgl_ctrl.sv =====
// ---------------------------------------------------------------------------
// bgl_ctrl
// sequencer: walks the micro-op list for one window, then steps the lines
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bgl_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire bgl_pkg::status_t status_i,
  output bgl_pkg::cmd_t         cmd_o,
  output logic                  busy_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]   state_q, state_d;
  bgl_pkg::op_e op_q, op_d;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    cmd_o.go  = 1'b0;
    cmd_o.op  = op_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.go = 1'b1;
          cmd_o.op = bgl_pkg::OP_LOAD;
          op_d     = bgl_pkg::OP_LOAD;
          state_d  = S_WAIT;
        end
      end
      S_ISSUE: begin
        cmd_o.go = 1'b1;
        state_d  = S_WAIT;
      end
      S_WAIT: begin
        if (status_i.done) begin
          state_d = S_ISSUE;
          case (op_q)
            bgl_pkg::OP_LOAD: begin
              if (status_i.degenerate) begin
                state_d = S_IDLE;
              end else begin
                op_d = bgl_pkg::OP_STEP;
              end
            end
            bgl_pkg::OP_STEP:  op_d = bgl_pkg::OP_BAR;
            bgl_pkg::OP_BAR:   op_d = bgl_pkg::OP_PHASE;
            bgl_pkg::OP_PHASE: op_d = bgl_pkg::OP_FIRST;
            bgl_pkg::OP_FIRST: op_d = bgl_pkg::OP_LAST;
            bgl_pkg::OP_LAST: begin
              if (status_i.empty) begin
                state_d = S_IDLE;
              end else begin
                op_d = bgl_pkg::OP_COUNT;
              end
            end
            bgl_pkg::OP_COUNT: begin
              op_d = status_i.over ? bgl_pkg::OP_BEATDIV : bgl_pkg::OP_ALIGN;
            end
            bgl_pkg::OP_BEATDIV: begin
              op_d = status_i.over ? bgl_pkg::OP_BARDIV : bgl_pkg::OP_ALIGN;
            end
            bgl_pkg::OP_BARDIV: begin
              op_d = status_i.over ? bgl_pkg::OP_CEILDIV : bgl_pkg::OP_ALIGN;
            end
            bgl_pkg::OP_CEILDIV:   op_d = bgl_pkg::OP_STRIDEMUL;
            bgl_pkg::OP_STRIDEMUL: op_d = bgl_pkg::OP_ALIGN;
            bgl_pkg::OP_ALIGN:     op_d = bgl_pkg::OP_INC;
            bgl_pkg::OP_INC:       op_d = bgl_pkg::OP_ACC;
            bgl_pkg::OP_ACC:       op_d = bgl_pkg::OP_NORM;
            bgl_pkg::OP_NORM:      op_d = bgl_pkg::OP_BEAT;
            bgl_pkg::OP_BEAT: begin
              op_d    = bgl_pkg::OP_EMIT;
              state_d = S_EMIT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_EMIT: begin
        cmd_o.op = bgl_pkg::OP_EMIT;
        if (!status_i.more) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.go = 1'b1;
          if (status_i.last_line) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= bgl_pkg::OP_LOAD;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/beat_grid_line_generator.sv =====
// ---------------------------------------------------------------------------
// beat_grid_line_generator
// lists the beat grid lines inside a time window, one request per window
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    window_start_us_i, window_end_us_i
//   out      source     out_valid_o / out_stall_i  line_time_us_o, on_bar_o, on_beat_o,
//                                                  beat_number_o, final_line_o
//   cfg      sink       apb psel / penable         tempo, subdivisions, beats, offset, limit
//
// after the window set-up, one line per cycle while out_stall_i is low
// set-up time is set by the shared bit-serial divider (seven to ten divides per
// window) and the shift-add multiplier
// degenerate settings or reversed windows hold in_stall_o for one cycle after the request
// in_stall_o stays high from the accepted request until the last line is loaded
// the output register holds a stalled line; reset empties it and idles the sequencer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module beat_grid_line_generator (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [31:0]  window_start_us_i,
  input  wire logic [31:0]  window_end_us_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic signed [33:0] line_time_us_o,
  output logic              on_bar_o,
  output logic              on_beat_o,
  output logic [4:0]        beat_number_o,
  output logic              final_line_o
);

  bgl_pkg::cfg_t    cfg_q, cfg_d;
  bgl_pkg::cmd_t    cmd;
  bgl_pkg::status_t status;
  logic             busy;
  logic [2:0]       reg_idx;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        bgl_pkg::REG_TEMPO:  cfg_d.tempo  = pwdata[16:0];
        bgl_pkg::REG_SUBDIV: cfg_d.subdiv = pwdata[4:0];
        bgl_pkg::REG_BEATS:  cfg_d.beats  = pwdata[4:0];
        bgl_pkg::REG_OFFSET: cfg_d.offset = $signed(pwdata);
        bgl_pkg::REG_LIMIT:  cfg_d.limit  = pwdata[6:0];
        default:             cfg_d        = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bgl_pkg::REG_TEMPO:  prdata = {15'd0, cfg_q.tempo};
      bgl_pkg::REG_SUBDIV: prdata = {27'd0, cfg_q.subdiv};
      bgl_pkg::REG_BEATS:  prdata = {27'd0, cfg_q.beats};
      bgl_pkg::REG_OFFSET: prdata = $unsigned(cfg_q.offset);
      bgl_pkg::REG_LIMIT:  prdata = {25'd0, cfg_q.limit};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tempo  <= bgl_pkg::TEMPO_RST;
      cfg_q.subdiv <= bgl_pkg::SUBDIV_RST;
      cfg_q.beats  <= bgl_pkg::BEATS_RST;
      cfg_q.offset <= $signed(bgl_pkg::OFFSET_RST);
      cfg_q.limit  <= bgl_pkg::LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = busy;

  bgl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  bgl_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .cmd_i             (cmd),
    .window_start_us_i (window_start_us_i),
    .window_end_us_i   (window_end_us_i),
    .status_o          (status),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .line_time_us_o    (line_time_us_o),
    .on_bar_o          (on_bar_o),
    .on_beat_o         (on_beat_o),
    .beat_number_o     (beat_number_o),
    .final_line_o      (final_line_o)
  );

endmodule

`default_nettype wire

// ===== hdl/bgl_chk.sv =====
// ---------------------------------------------------------------------------
// bgl_chk
// port-level checks on the beat grid line generator, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "beat_grid_line_generator_macros.svh"

module bgl_chk (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic signed [33:0] line_time_us_o,
  input wire logic              on_bar_o,
  input wire logic              on_beat_o,
  input wire logic [4:0]        beat_number_o,
  input wire logic              final_line_o
);

  `BGL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `BGL_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(line_time_us_o) && $stable(beat_number_o) && $stable(final_line_o))
  `BGL_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)
  `BGL_ASSERT_NOW(a_bar_is_beat, out_valid_o && on_bar_o, on_beat_o && (beat_number_o == 5'd0))

endmodule

bind beat_grid_line_generator bgl_chk u_bgl_chk (.*);

`default_nettype wire
